### hdl/daisy_chain_link_controller_assert.svh
// Assertion macros for the checker file of the daisy-chain link controller.
// Needs clk and rst in the scope where a macro is used.
`ifndef DAISY_CHAIN_LINK_CONTROLLER_ASSERT_SVH
`define DAISY_CHAIN_LINK_CONTROLLER_ASSERT_SVH

// Clocked check, masked while reset is held.
`define DCLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define DCLC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/dclc_pkg.sv
// Types and constants for the daisy-chain link controller.
// No dependencies; used by dclc_core, the top level and the checker.
package dclc_pkg;

  // Link phases
  localparam logic [1:0] PH_RESET   = 2'd0;
  localparam logic [1:0] PH_SETUP   = 2'd1;
  localparam logic [1:0] PH_STANDBY = 2'd2;
  localparam logic [1:0] PH_ACTIVE  = 2'd3;

  // Event kinds
  localparam logic [1:0] ACT_POLL  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_RAISE = 2'd2;
  localparam logic [1:0] ACT_DOWN  = 2'd3;

  // Config byte bits
  localparam logic [7:0] CFG_PULLUPS   = 8'h01;
  localparam logic [7:0] CFG_DISABLE   = 8'h02;
  localparam logic [7:0] CFG_INTERRUPT = 8'h80;

  // Configuration registers
  localparam logic [7:0] REG_DEFAULT_ADDRESS = 8'd0;
  localparam logic [7:0] REG_PULSE_LIMIT     = 8'd1;
  localparam logic [6:0] DEFAULT_ADDRESS_RST = 7'd127;
  localparam logic [15:0] PULSE_LIMIT_RST    = 16'd10;

  typedef struct packed {
    logic [1:0] action;
    logic       upstream_active;
    logic       downstream_active;
    logic [7:0] host_id;
    logic [7:0] host_config;
  } link_event_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] stored_id;
    logic [7:0] stored_config;
    logic       pulse_on;
    logic       driving_upstream;
    logic [7:0] answer_address;
    logic       pullup_enable;
    logic       downstream_released;
  } link_state_t;

  // Packed so that the first field sits in the highest bits.
  typedef struct packed {
    logic [7:0] image_config;
    logic [7:0] image_id;
    logic       config_write;
    logic       id_write;
    logic       release_downstream;
    logic       drive_upstream;
    logic       pullups_on;
    logic [7:0] bus_address;
    logic [1:0] link_phase;
    logic       module_active;
  } link_result_t;

  // State after a link reset (tick counter handled by the caller).
  function automatic link_state_t link_cleared();
    link_state_t s;
    s.phase               = PH_RESET;
    s.stored_id           = 8'd0;
    s.stored_config       = CFG_DISABLE;
    s.pulse_on            = 1'b0;
    s.driving_upstream    = 1'b0;
    s.answer_address      = 8'd0;
    s.pullup_enable       = 1'b0;
    s.downstream_released = 1'b0;
    return s;
  endfunction

endpackage

### hdl/daisy_chain_link_controller.sv
// Daisy-chain link controller: one request in, one result out, per event.
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while m_tready is high; the input register and
// result register let a new request in while the previous result waits on m_tready.
// Reset (rst, synchronous): link state to the reset phase, tick and pulse start
// to zero, default_address to 127, pulse_limit to 10, both stream stages empty.
module daisy_chain_link_controller import dclc_pkg::*; #(
  parameter int TICK_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] upstream_active, [1] downstream_active, [9:2] host_id,
  // [17:10] host_config, [23:18] zero
  input  logic [23:0] s_tdata,
  // [1:0] action
  input  logic [1:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] module_active, [2:1] link_phase, [10:3] bus_address, [11] pullups_on,
  // [12] drive_upstream, [13] release_downstream, [14] id_write,
  // [15] config_write, [23:16] image_id, [31:24] image_config
  output logic [31:0] m_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [6:0]   default_address;
  logic [15:0]  pulse_limit;
  logic         in_full;
  link_event_t  in_ev;
  logic         advance;
  link_result_t result;
  link_result_t out_res;
  logic         out_valid;

  // Configuration port never stalls; writes outside the register list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_address <= DEFAULT_ADDRESS_RST;
      pulse_limit     <= PULSE_LIMIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DEFAULT_ADDRESS) begin
        default_address <= cfg_data[6:0];
      end else if (cfg_index == REG_PULSE_LIMIT) begin
        pulse_limit <= cfg_data;
      end
    end
  end

  // Advance the held request into the result register when that register is
  // empty or being drained this cycle. The link state updates on the same edge.
  assign advance  = in_full && (!out_valid || m_tready);
  assign s_tready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // Payload register: no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ev.action            <= s_tuser;
      in_ev.upstream_active   <= s_tdata[0];
      in_ev.downstream_active <= s_tdata[1];
      in_ev.host_id           <= s_tdata[9:2];
      in_ev.host_config       <= s_tdata[17:10];
    end
  end

  dclc_core #(
    .TICK_BITS (TICK_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .ev              (in_ev),
    .default_address (default_address),
    .pulse_limit     (pulse_limit),
    .result          (result)
  );

  // Result register: hold while the sink stalls, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res;

endmodule

### hdl/dclc_core.sv
// Link state registers and the per-event update logic.
// Depends on dclc_pkg.
module dclc_core import dclc_pkg::*; #(
  parameter int TICK_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  link_event_t  ev,
  input  logic [6:0]   default_address,
  input  logic [15:0]  pulse_limit,
  output link_result_t result
);

  localparam int CmpW = (TICK_BITS > 16) ? TICK_BITS : 16;

  link_state_t          st, st_next;
  logic [TICK_BITS-1:0] tick_count, tick_count_next;
  logic [TICK_BITS-1:0] pulse_start, pulse_start_next;
  logic [TICK_BITS-1:0] pulse_gap;
  logic                 pulse_expired;
  logic                 wid, wcfg;

  assign pulse_gap     = tick_count - pulse_start;
  assign pulse_expired = CmpW'(pulse_gap) > CmpW'(pulse_limit);

  always_comb begin
    st_next          = st;
    tick_count_next  = tick_count;
    pulse_start_next = pulse_start;
    wid              = 1'b0;
    wcfg             = 1'b0;
    case (ev.action)
      ACT_POLL: begin
        case (st.phase)
          PH_RESET: begin
            if (!ev.upstream_active) begin
              st_next.phase          = PH_SETUP;
              st_next.stored_id      = {1'b0, default_address};
              st_next.answer_address = {1'b0, default_address};
              st_next.pullup_enable  = 1'b1;
              wid  = 1'b1;
              wcfg = 1'b1;
            end
          end
          PH_SETUP: begin
            if (ev.upstream_active) begin
              st_next         = link_cleared();
              tick_count_next = '0;
              wid  = 1'b1;
              wcfg = 1'b1;
            end else if (ev.host_id != {1'b0, default_address}) begin
              st_next.stored_id           = ev.host_id;
              st_next.answer_address      = ev.host_id;
              st_next.phase               = PH_STANDBY;
              st_next.downstream_released = 1'b1;
            end
          end
          PH_STANDBY: begin
            if (ev.upstream_active) begin
              st_next         = link_cleared();
              tick_count_next = '0;
              wid  = 1'b1;
              wcfg = 1'b1;
            end else if ((ev.host_config & CFG_DISABLE) == 8'd0) begin
              st_next.stored_config = ev.host_config & CFG_PULLUPS;
              if ((ev.host_config & CFG_PULLUPS) == 8'd0) begin
                st_next.pullup_enable = 1'b0;
              end
              st_next.phase = PH_ACTIVE;
              wid  = 1'b1;
              wcfg = 1'b1;
            end
          end
          default: begin
            // Host clearing the interrupt bit ends our own pulse.
            if ((st.stored_config & CFG_INTERRUPT) != 8'd0) begin
              if ((ev.host_config & CFG_INTERRUPT) == 8'd0) begin
                st_next.stored_config = st.stored_config & ~CFG_INTERRUPT;
                st_next.pulse_on      = 1'b0;
                wcfg = 1'b1;
              end
              wid = 1'b1;
            end else begin
              wid  = 1'b1;
              wcfg = 1'b1;
            end
            if (st_next.pulse_on && pulse_expired) begin
              st_next.pulse_on = 1'b0;
            end
            if (ev.downstream_active) begin
              st_next.driving_upstream = 1'b1;
            end else if (st_next.driving_upstream && !st_next.pulse_on) begin
              st_next.driving_upstream = 1'b0;
            end
            // Upstream line active while we are not driving it: lost upstream.
            if (!st_next.driving_upstream && ev.upstream_active) begin
              st_next         = link_cleared();
              tick_count_next = '0;
              wid  = 1'b1;
              wcfg = 1'b1;
            end
          end
        endcase
      end
      ACT_TICK: begin
        tick_count_next = tick_count + TICK_BITS'(1);
      end
      ACT_RAISE: begin
        st_next.stored_config    = st.stored_config | CFG_INTERRUPT;
        st_next.driving_upstream = 1'b1;
        st_next.pulse_on         = 1'b1;
        pulse_start_next         = tick_count;
        wid  = 1'b1;
        wcfg = 1'b1;
      end
      default: begin
        if (st.phase == PH_ACTIVE) begin
          if (ev.downstream_active) begin
            st_next.driving_upstream = 1'b1;
          end else if (!st.pulse_on) begin
            st_next.driving_upstream = 1'b0;
          end
        end
      end
    endcase
  end

  always_comb begin
    result.module_active      = (st_next.phase == PH_ACTIVE);
    result.link_phase         = st_next.phase;
    result.bus_address        = st_next.answer_address;
    result.pullups_on         = st_next.pullup_enable;
    result.drive_upstream     = st_next.driving_upstream;
    result.release_downstream = st_next.downstream_released;
    result.id_write           = wid;
    result.config_write       = wcfg;
    result.image_id           = st_next.stored_id;
    result.image_config       = st_next.stored_config;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= link_cleared();
      tick_count  <= '0;
      pulse_start <= '0;
    end else if (step) begin
      st          <= st_next;
      tick_count  <= tick_count_next;
      pulse_start <= pulse_start_next;
    end
  end

endmodule

### hdl/dclc_checker.sv
// Port-level checks for the daisy-chain link controller, bound to the top level.
// Depends on dclc_pkg and daisy_chain_link_controller_assert.svh.
`include "daisy_chain_link_controller_assert.svh"

module dclc_checker import dclc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result stays put.
  `DCLC_ASSERT(a_result_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  // Module function is on exactly in the active phase.
  `DCLC_ASSERT(a_active_flag, m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == PH_ACTIVE)), "module_active disagrees with link_phase")

  // In reset the node is silent: no address, no pullups, downstream held, ID cleared.
  `DCLC_ASSERT(a_reset_silent, m_tvalid && (m_tdata[2:1] == PH_RESET) |-> (m_tdata[10:3] == 8'd0) && !m_tdata[11] && !m_tdata[13] && (m_tdata[23:16] == 8'd0), "reset phase not silent")

  // Downstream is released exactly in standby and active.
  `DCLC_ASSERT(a_release_phase, m_tvalid |-> (m_tdata[13] == m_tdata[2]), "release_downstream disagrees with link_phase")

  // Nothing comes out right after reset.
  `DCLC_ASSERT_ALWAYS(a_empty_after_reset, $past(rst) |-> !m_tvalid, "result valid right after reset")

endmodule

bind daisy_chain_link_controller dclc_checker u_checker (.*);

### bench/testbench.sv
// Self-checking bench for the daisy-chain link controller: sends link events and
// register writes with random idling, predicts each result and compares it.
// Depends on dclc_pkg and daisy_chain_link_controller.
`timescale 1ns / 1ps

module testbench;
  import dclc_pkg::*;

  // Tracks the node's link state, predicts the result of each accepted request
  // and holds the predictions until the matching results come out.
  class link_node_tracker;
    logic [6:0]   default_address;
    logic [15:0]  pulse_limit;
    logic [1:0]   phase;
    logic [7:0]   stored_id;
    logic [7:0]   stored_config;
    logic [7:0]   answer_address;
    bit           pulse_on;
    bit           driving_up;
    bit           pullup_en;
    bit           down_released;
    logic [15:0]  tick_count;
    logic [15:0]  pulse_start;
    link_result_t expected_results[$];
    int           mismatches;

    function new();
      default_address = DEFAULT_ADDRESS_RST;
      pulse_limit     = PULSE_LIMIT_RST;
      pulse_start     = 16'd0;
      mismatches      = 0;
      clear_link();
    endfunction

    // Link reset: everything back to the reset phase except the pulse start.
    function void clear_link();
      phase          = PH_RESET;
      pulse_on       = 1'b0;
      driving_up     = 1'b0;
      tick_count     = 16'd0;
      down_released  = 1'b0;
      pullup_en      = 1'b0;
      stored_id      = 8'd0;
      stored_config  = CFG_DISABLE;
      answer_address = 8'd0;
    endfunction

    function void set_register(logic [7:0] index, logic [15:0] value);
      case (index)
        REG_DEFAULT_ADDRESS: default_address = value[6:0];
        REG_PULSE_LIMIT:     pulse_limit = value;
        default: ;
      endcase
    endfunction

    function void note_request(link_event_t ev);
      bit           wid;
      bit           wcfg;
      logic [15:0]  elapsed;
      link_result_t r;
      wid  = 1'b0;
      wcfg = 1'b0;
      case (ev.action)
        ACT_POLL: begin
          case (phase)
            PH_RESET: begin
              if (!ev.upstream_active) begin
                phase          = PH_SETUP;
                stored_id      = {1'b0, default_address};
                answer_address = {1'b0, default_address};
                pullup_en      = 1'b1;
                wid            = 1'b1;
                wcfg           = 1'b1;
              end
            end
            PH_SETUP: begin
              if (ev.upstream_active) begin
                clear_link();
                wid  = 1'b1;
                wcfg = 1'b1;
              end else if (ev.host_id != {1'b0, default_address}) begin
                stored_id      = ev.host_id;
                answer_address = ev.host_id;
                down_released  = 1'b1;
                phase          = PH_STANDBY;
              end
            end
            PH_STANDBY: begin
              if (ev.upstream_active) begin
                clear_link();
                wid  = 1'b1;
                wcfg = 1'b1;
              end else if ((ev.host_config & CFG_DISABLE) == 8'd0) begin
                stored_config = ev.host_config & CFG_PULLUPS;
                if ((stored_config & CFG_PULLUPS) == 8'd0) pullup_en = 1'b0;
                wid   = 1'b1;
                wcfg  = 1'b1;
                phase = PH_ACTIVE;
              end
            end
            default: begin
              // Host clearing the interrupt bit ends the own pulse early.
              if ((stored_config & CFG_INTERRUPT) != 8'd0) begin
                if ((ev.host_config & CFG_INTERRUPT) == 8'd0) begin
                  stored_config = stored_config & ~CFG_INTERRUPT;
                  wcfg          = 1'b1;
                  pulse_on      = 1'b0;
                end
                wid = 1'b1;
              end else begin
                wid  = 1'b1;
                wcfg = 1'b1;
              end
              elapsed = tick_count - pulse_start;
              if (pulse_on && elapsed > pulse_limit) pulse_on = 1'b0;
              if (ev.downstream_active) driving_up = 1'b1;
              else if (driving_up && !pulse_on) driving_up = 1'b0;
              if (!driving_up && ev.upstream_active) begin
                clear_link();
                wid  = 1'b1;
                wcfg = 1'b1;
              end
            end
          endcase
        end
        ACT_TICK: tick_count = tick_count + 16'd1;
        ACT_RAISE: begin
          stored_config = stored_config | CFG_INTERRUPT;
          driving_up    = 1'b1;
          pulse_start   = tick_count;
          pulse_on      = 1'b1;
          wid           = 1'b1;
          wcfg          = 1'b1;
        end
        default: begin
          if (phase == PH_ACTIVE) begin
            if (ev.downstream_active) driving_up = 1'b1;
            else if (!pulse_on) driving_up = 1'b0;
          end
        end
      endcase
      r.module_active      = (phase == PH_ACTIVE);
      r.link_phase         = phase;
      r.bus_address        = answer_address;
      r.pullups_on         = pullup_en;
      r.drive_upstream     = driving_up;
      r.release_downstream = down_released;
      r.id_write           = wid;
      r.config_write       = wcfg;
      r.image_id           = stored_id;
      r.image_config       = stored_config;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [31:0] raw);
      link_result_t got;
      link_result_t want;
      got = raw;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none got %h", $time, raw);
        return;
      end
      want = expected_results.pop_front();
      compare_field("module_active", want.module_active, got.module_active);
      compare_field("link_phase", want.link_phase, got.link_phase);
      compare_field("bus_address", want.bus_address, got.bus_address);
      compare_field("pullups_on", want.pullups_on, got.pullups_on);
      compare_field("drive_upstream", want.drive_upstream, got.drive_upstream);
      compare_field("release_downstream", want.release_downstream, got.release_downstream);
      compare_field("id_write", want.id_write, got.id_write);
      compare_field("config_write", want.config_write, got.config_write);
      compare_field("image_id", want.image_id, got.image_id);
      compare_field("image_config", want.image_config, got.image_config);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;

  link_node_tracker tracker;
  // When set, neither side idles: gives stretches of back-to-back traffic.
  bit calm;

  daisy_chain_link_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic link_event_t make_event(logic [1:0] kind, logic up, logic down,
                                             logic [7:0] id, logic [7:0] cfg);
    link_event_t ev;
    ev.action            = kind;
    ev.upstream_active   = up;
    ev.downstream_active = down;
    ev.host_id           = id;
    ev.host_config       = cfg;
    return ev;
  endfunction

  // Random event: mostly polls and ticks, upstream rarely active so the node
  // tends to stay up once it gets there.
  function automatic link_event_t random_event();
    int          roll;
    logic [1:0]  kind;
    logic [7:0]  id;
    roll = $urandom_range(0, 99);
    if (roll < 35) kind = ACT_POLL;
    else if (roll < 60) kind = ACT_TICK;
    else if (roll < 72) kind = ACT_RAISE;
    else kind = ACT_DOWN;
    id = ($urandom_range(0, 9) == 0) ? {1'b0, tracker.default_address} : 8'($urandom);
    return make_event(kind, $urandom_range(0, 99) < 8, 1'($urandom), id, 8'($urandom));
  endfunction

  // Call at a falling edge; returns at a falling edge after the request is taken
  // and after any idle time that follows it.
  task automatic send_request(input link_event_t ev);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= ev.action;
    s_tdata  <= {6'd0, ev.host_config, ev.host_id, ev.downstream_active, ev.upstream_active};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(ev);
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold the request side until every predicted result has come out, then let
  // extra cycles pass for anything still in flight.
  task automatic drain_results(input int extra);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.expected_results.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it.
  task automatic write_register(input logic [7:0] index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(index, value);
    @(negedge clk);
  endtask

  // Block is idle here once the result register has drained.
  task automatic apply_settings(input logic [6:0] addr, input logic [15:0] limit);
    drain_results(4);
    write_register(REG_DEFAULT_ADDRESS, {9'd0, addr});
    write_register(REG_PULSE_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  // Three polls with upstream released, a new ID and the disable bit clear walk
  // the node from any phase into active.
  task automatic bring_up();
    logic [7:0] id;
    repeat (3) begin
      id = 8'($urandom);
      if (id == {1'b0, tracker.default_address}) id = id ^ 8'h80;
      send_request(make_event(ACT_POLL, 1'b0, 1'($urandom), id,
                              8'($urandom) & ~CFG_DISABLE));
    end
  endtask

  // Episodes of random traffic, most of them opened by a clean bring-up.
  task automatic run_random(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      calm = ($urandom_range(0, 3) == 0);
      // pause now and then until the block has answered everything
      if ($urandom_range(0, 7) == 0) drain_results(0);
      if ($urandom_range(0, 9) < 7) begin
        bring_up();
        sent += 3;
      end
      len = $urandom_range(5, 30);
      repeat (len) send_request(random_event());
      sent += len;
    end
    calm = 1'b0;
  endtask

  // Raise a pulse in the active phase and poll once inside the pulse limit and
  // once past it: the first poll keeps the line driven, the second releases it.
  // Run back to back to keep the stretch short.
  task automatic pulse_expiry();
    calm = 1'b1;
    bring_up();
    send_request(make_event(ACT_RAISE, 1'b0, 1'b0, 8'h11, 8'h80));
    repeat (15) send_request(make_event(ACT_TICK, 1'b0, 1'b0, 8'h00, 8'h00));
    send_request(make_event(ACT_POLL, 1'b0, 1'b0, 8'h11, CFG_INTERRUPT));
    repeat (8) send_request(make_event(ACT_TICK, 1'b0, 1'b0, 8'h00, 8'h00));
    send_request(make_event(ACT_POLL, 1'b0, 1'b0, 8'h11, CFG_INTERRUPT));
    send_request(make_event(ACT_POLL, 1'b1, 1'b0, 8'h11, CFG_INTERRUPT));
    calm = 1'b0;
  endtask

  // Result side: stall at random, sample at the rising edge.
  initial begin
    int hold;
    hold = 0;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  // Safety net, several times the slowest passing run.
  initial begin
    #3_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    tracker   = new();
    calm      = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 24'd0;
    s_tuser   = ACT_POLL;
    cfg_valid = 1'b0;
    cfg_index = REG_DEFAULT_ADDRESS;
    cfg_data  = 16'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed walk at the reset settings (address 127, pulse limit 10).
    send_request(make_event(ACT_POLL,  1'b1, 1'b0, 8'h00, 8'h00)); // upstream held
    send_request(make_event(ACT_TICK,  1'b0, 1'b0, 8'h00, 8'h00));
    send_request(make_event(ACT_DOWN,  1'b0, 1'b1, 8'h00, 8'h00)); // ignored in reset
    send_request(make_event(ACT_RAISE, 1'b0, 1'b0, 8'h00, 8'h00)); // raise in reset
    send_request(make_event(ACT_POLL,  1'b0, 1'b0, 8'h00, 8'h00)); // into setup
    send_request(make_event(ACT_POLL,  1'b0, 1'b0, 8'h7F, 8'hFF)); // ID still default
    send_request(make_event(ACT_POLL,  1'b1, 1'b0, 8'h00, 8'h00)); // link reset from setup
    send_request(make_event(ACT_POLL,  1'b0, 1'b0, 8'h00, 8'h00));
    send_request(make_event(ACT_RAISE, 1'b0, 1'b0, 8'h00, 8'h00)); // raise in setup
    send_request(make_event(ACT_POLL,  1'b0, 1'b0, 8'hFF, 8'hFF)); // into standby
    send_request(make_event(ACT_POLL,  1'b0, 1'b0, 8'hFF, 8'h82)); // still disabled
    send_request(make_event(ACT_POLL,  1'b0, 1'b1, 8'hFF, 8'h01)); // active, pullups
    send_request(make_event(ACT_RAISE, 1'b0, 1'b0, 8'hFF, 8'h01));
    send_request(make_event(ACT_TICK,  1'b0, 1'b0, 8'hFF, 8'h81));
    send_request(make_event(ACT_POLL,  1'b0, 1'b0, 8'hFF, 8'h80)); // pulse kept
    send_request(make_event(ACT_DOWN,  1'b0, 1'b1, 8'hFF, 8'h80));
    send_request(make_event(ACT_DOWN,  1'b0, 1'b0, 8'hFF, 8'h80)); // pulse holds the line
    send_request(make_event(ACT_POLL,  1'b0, 1'b0, 8'hFF, 8'h00)); // host clears interrupt
    send_request(make_event(ACT_POLL,  1'b1, 1'b1, 8'hFF, 8'h00)); // driving, no reset
    send_request(make_event(ACT_DOWN,  1'b1, 1'b0, 8'hFF, 8'h00));
    send_request(make_event(ACT_POLL,  1'b1, 1'b0, 8'hFF, 8'h00)); // lost upstream
    send_request(make_event(ACT_POLL,  1'b0, 1'b0, 8'h00, 8'h00));
    send_request(make_event(ACT_POLL,  1'b0, 1'b0, 8'h05, 8'h02)); // into standby
    send_request(make_event(ACT_POLL,  1'b1, 1'b0, 8'h05, 8'h00)); // reset from standby

    // Random phases across the register extremes and a few middle settings.
    apply_settings(7'd0, 16'd0);
    run_random(250);
    apply_settings(7'd127, 16'hFFFF);
    run_random(250);
    apply_settings(7'($urandom), 16'd20);
    pulse_expiry();
    run_random(250);
    apply_settings(7'($urandom), 16'($urandom_range(1, 30)));
    run_random(300);

    drain_results(4);
    if (tracker.mismatches == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
